// ===== rtl/prpi_pkg.sv =====
`timescale 1ns / 1ps
package prpi_pkg;

  // Table sizes and field widths.
  localparam int MAX_PAGES  = 1024;
  localparam int MAX_EDGES  = 8192;
  localparam int PAGE_W     = 10;
  localparam int PAGE_CNT_W = 11;
  localparam int EDGE_W     = 13;
  localparam int EDGE_CNT_W = 14;
  localparam int DEG_W      = 14;
  localparam int Q_W        = 32;
  localparam int ITER_W     = 8;
  localparam int EDGE_DATA_W = 2 * PAGE_W;

  localparam logic [DEG_W-1:0]  DEG_MAX    = 14'd16383;
  localparam logic [ITER_W-1:0] ITER_RESET = 8'd50;

  // Divider sizes: a 36-bit dividend covers 9 * weight and 2^32.
  localparam int DIVD_W = 36;
  localparam int DIVS_W = 18;
  localparam int DCNT_W = 6;

  typedef enum logic [1:0] {
    REQ_PAGE = 2'd0,
    REQ_LINK = 2'd1,
    REQ_RANK = 2'd2,
    REQ_READ = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    DIV_SEL_START = 2'd0,
    DIV_SEL_BASE  = 2'd1,
    DIV_SEL_SHARE = 2'd2
  } div_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     reject;
    logic     page_add;
    logic     link_begin;
    logic     link_end;
    logic     read_begin;
    logic     read_end;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_start;
    logic     take_base;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     pass_clr;
    logic     pass_inc;
    logic     init_wr;
    logic     next_init_wr;
    logic     edge_rd;
    logic     edge_take;
    logic     src_rd;
    logic     next_rd;
    logic     acc_wr;
    logic     copy_rd;
    logic     copy_wr;
    logic     emit;
  } prpi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_t req;
    logic page_full;
    logic link_bad;
    logic read_bad;
    logic pt_zero;
    logic div_busy;
    logic sweep_done;
    logic edge_done;
    logic pass_done;
    logic edge_skip;
    logic deg_zero;
    logic out_free;
  } prpi_stat_t;

endpackage

// ===== rtl/prpi_if.sv =====
`timescale 1ns / 1ps
interface prpi_req_if;
  import prpi_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic [PAGE_W-1:0]   page_index;
  modport source (output valid, req_type, page_index, input ready);
  modport sink (input valid, req_type, page_index, output ready);
endinterface

interface prpi_res_if;
  import prpi_pkg::*;
  logic             valid;
  logic             ready;
  logic [Q_W-1:0]   rank_value;
  logic             status;
  modport source (output valid, rank_value, status, input ready);
  modport sink (input valid, rank_value, status, output ready);
endinterface

// ===== rtl/prpi_ram.sv =====
`timescale 1ns / 1ps
module prpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/prpi_div.sv =====
`timescale 1ns / 1ps
module prpi_div
  import prpi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              busy,
  output logic [DIVD_W-1:0] quotient
);

  logic [DIVD_W-1:0] quo_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dvs_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic [DIVS_W:0]   rem_sh;
  logic [DIVS_W:0]   rem_sub;
  logic              ge;

  // One restoring step per cycle.
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIVD_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r) begin
      busy_r <= (cnt_r != DCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      cnt_r <= DCNT_W'(DIVD_W);
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVD_W-2:0], ge};
      rem_r <= ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
      cnt_r <= cnt_r - DCNT_W'(1);
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/prpi_ctrl.sv =====
`timescale 1ns / 1ps
module prpi_ctrl
  import prpi_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  prpi_stat_t stat,
  output prpi_cmd_t  cmd
);

  typedef enum logic [20:0] {
    S_IDLE     = 21'h000001,
    S_DECODE   = 21'h000002,
    S_LINK_END = 21'h000004,
    S_READ_END = 21'h000008,
    S_DIV_ST   = 21'h000010,
    S_WAIT_ST  = 21'h000020,
    S_DIV_BS   = 21'h000040,
    S_WAIT_BS  = 21'h000080,
    S_INIT     = 21'h000100,
    S_PASS     = 21'h000200,
    S_NINIT    = 21'h000400,
    S_ECHK     = 21'h000800,
    S_EWAIT    = 21'h001000,
    S_ESKIP    = 21'h002000,
    S_EDATA    = 21'h004000,
    S_EDIV     = 21'h008000,
    S_EACC     = 21'h010000,
    S_CRD      = 21'h020000,
    S_CWR      = 21'h040000,
    S_FINISH   = 21'h080000,
    S_ENRD     = 21'h100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.req)
          REQ_PAGE: begin
            if (stat.page_full) cmd.reject = 1'b1;
            else cmd.page_add = 1'b1;
            state_nxt = S_FINISH;
          end
          REQ_LINK: begin
            if (stat.link_bad) begin
              cmd.reject = 1'b1;
              state_nxt  = S_FINISH;
            end else begin
              cmd.link_begin = 1'b1;
              state_nxt      = S_LINK_END;
            end
          end
          REQ_RANK: begin
            state_nxt = stat.pt_zero ? S_FINISH : S_DIV_ST;
          end
          default: begin
            if (stat.read_bad) begin
              cmd.reject = 1'b1;
              state_nxt  = S_FINISH;
            end else begin
              cmd.read_begin = 1'b1;
              state_nxt      = S_READ_END;
            end
          end
        endcase
      end
      S_LINK_END: begin
        cmd.link_end = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_READ_END: begin
        cmd.read_end = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_DIV_ST: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_START;
        state_nxt     = S_WAIT_ST;
      end
      S_WAIT_ST: begin
        if (!stat.div_busy) begin
          cmd.take_start = 1'b1;
          state_nxt      = S_DIV_BS;
        end
      end
      S_DIV_BS: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_BASE;
        state_nxt     = S_WAIT_BS;
      end
      S_WAIT_BS: begin
        if (!stat.div_busy) begin
          cmd.take_base = 1'b1;
          cmd.cnt_clr   = 1'b1;
          cmd.pass_clr  = 1'b1;
          state_nxt     = S_INIT;
        end
      end
      S_INIT: begin
        if (stat.sweep_done) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_PASS;
        end else begin
          cmd.init_wr = 1'b1;
          cmd.cnt_inc = 1'b1;
        end
      end
      S_PASS: begin
        cmd.cnt_clr = 1'b1;
        state_nxt   = stat.pass_done ? S_FINISH : S_NINIT;
      end
      S_NINIT: begin
        if (stat.sweep_done) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_ECHK;
        end else begin
          cmd.next_init_wr = 1'b1;
          cmd.cnt_inc      = 1'b1;
        end
      end
      S_ECHK: begin
        if (stat.edge_done) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_CRD;
        end else begin
          cmd.edge_rd = 1'b1;
          state_nxt   = S_EWAIT;
        end
      end
      S_EWAIT: begin
        cmd.edge_take = 1'b1;
        state_nxt     = S_ESKIP;
      end
      S_ESKIP: begin
        if (stat.edge_skip) begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_ECHK;
        end else begin
          cmd.src_rd = 1'b1;
          state_nxt  = S_EDATA;
        end
      end
      S_EDATA: begin
        if (stat.deg_zero) begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_ECHK;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SEL_SHARE;
          state_nxt     = S_EDIV;
        end
      end
      S_EDIV: begin
        if (!stat.div_busy) begin
          cmd.next_rd = 1'b1;
          state_nxt   = S_ENRD;
        end
      end
      S_ENRD: begin
        state_nxt = S_EACC;
      end
      S_EACC: begin
        cmd.acc_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_ECHK;
      end
      S_CRD: begin
        if (stat.sweep_done) begin
          cmd.pass_inc = 1'b1;
          state_nxt    = S_PASS;
        end else begin
          cmd.copy_rd = 1'b1;
          state_nxt   = S_CWR;
        end
      end
      S_CWR: begin
        cmd.copy_wr = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_CRD;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A divider result is only taken after the divider has gone idle.
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take_start || cmd.take_base) |-> !stat.div_busy)
    else $error("divider result taken while busy");

  // A result leaves only when the output register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result emitted over a pending result");

  // An accepted request is decoded in the next cycle.
  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_DECODE)
    else $error("request not decoded after capture");

endmodule

// ===== rtl/prpi_dp.sv =====
`timescale 1ns / 1ps
module prpi_dp
  import prpi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  prpi_cmd_t         cmd,
  output prpi_stat_t        stat,
  input  logic [1:0]        in_req_type,
  input  logic [PAGE_W-1:0] in_page_index,
  input  logic              cfg_we,
  input  logic [ITER_W-1:0] cfg_wdata,
  output logic [ITER_W-1:0] iter_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [Q_W-1:0]    out_rank_value,
  output logic              out_status
);

  req_t                   req_r;
  logic [PAGE_W-1:0]      idx_r;
  logic [PAGE_CNT_W-1:0]  pt_r;
  logic [EDGE_CNT_W-1:0]  et_r;
  logic [EDGE_CNT_W-1:0]  cnt_r;
  logic [ITER_W-1:0]      pass_r;
  logic [ITER_W-1:0]      iter_r;
  logic [Q_W-1:0]         start_r;
  logic [Q_W-1:0]         base_r;
  logic [PAGE_W-1:0]      src_r;
  logic [PAGE_W-1:0]      dst_r;
  logic [Q_W-1:0]         res_value_r;
  logic                   res_status_r;
  logic                   out_valid_r;
  logic [Q_W-1:0]         out_value_r;
  logic                   out_status_r;

  logic                   deg_we;
  logic [PAGE_W-1:0]      deg_addr;
  logic [DEG_W-1:0]       deg_wdata;
  logic [DEG_W-1:0]       deg_rdata;
  logic                   rank_we;
  logic [PAGE_W-1:0]      rank_addr;
  logic [Q_W-1:0]         rank_wdata;
  logic [Q_W-1:0]         rank_rdata;
  logic                   next_we;
  logic [PAGE_W-1:0]      next_addr;
  logic [Q_W-1:0]         next_wdata;
  logic [Q_W-1:0]         next_rdata;
  logic                   edge_we;
  logic [EDGE_W-1:0]      edge_addr;
  logic [EDGE_DATA_W-1:0] edge_wdata;
  logic [EDGE_DATA_W-1:0] edge_rdata;

  logic [PAGE_W-1:0]      last_page;
  logic [PAGE_W-1:0]      sweep_idx;
  logic [DIVD_W-1:0]      div_dividend;
  logic [DIVS_W-1:0]      div_divisor;
  logic                   div_busy;
  logic [DIVD_W-1:0]      div_quo;
  logic [Q_W:0]           acc_sum;
  logic                   out_free;

  assign last_page = pt_r[PAGE_W-1:0] - PAGE_W'(1);
  assign sweep_idx = cnt_r[PAGE_W-1:0];
  assign out_free  = !out_valid_r || out_ready;

  // Status toward the controller.
  always_comb begin
    stat.req        = req_r;
    stat.page_full  = (pt_r == PAGE_CNT_W'(MAX_PAGES));
    stat.link_bad   = (pt_r == '0) || (et_r == EDGE_CNT_W'(MAX_EDGES)) ||
                      ({1'b0, idx_r} >= PAGE_CNT_W'(MAX_PAGES));
    stat.read_bad   = ({1'b0, idx_r} >= pt_r);
    stat.pt_zero    = (pt_r == '0);
    stat.div_busy   = div_busy;
    stat.sweep_done = (cnt_r == EDGE_CNT_W'(pt_r));
    stat.edge_done  = (cnt_r == et_r);
    stat.pass_done  = (pass_r == iter_r);
    stat.edge_skip  = ({1'b0, src_r} >= pt_r) || ({1'b0, dst_r} >= pt_r);
    stat.deg_zero   = (deg_rdata == '0);
    stat.out_free   = out_free;
  end

  // Divider operand selection.
  always_comb begin
    case (cmd.div_sel)
      DIV_SEL_START: begin
        div_dividend = DIVD_W'(1) << Q_W;
        div_divisor  = DIVS_W'(pt_r);
      end
      DIV_SEL_BASE: begin
        div_dividend = DIVD_W'(1) << Q_W;
        div_divisor  = (DIVS_W'(pt_r) << 3) + (DIVS_W'(pt_r) << 1);
      end
      default: begin
        div_dividend = (DIVD_W'(rank_rdata) << 3) + DIVD_W'(rank_rdata);
        div_divisor  = (DIVS_W'(deg_rdata) << 3) + (DIVS_W'(deg_rdata) << 1);
      end
    endcase
  end

  prpi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Out-degree table port.
  always_comb begin
    deg_we    = cmd.page_add || cmd.link_end;
    deg_addr  = src_r;
    deg_wdata = (deg_rdata < DEG_MAX) ? deg_rdata + DEG_W'(1) : deg_rdata;
    if (cmd.page_add) begin
      deg_addr  = pt_r[PAGE_W-1:0];
      deg_wdata = '0;
    end else if (cmd.link_begin || cmd.link_end) begin
      deg_addr = last_page;
    end
  end

  // Weight table port.
  always_comb begin
    rank_we    = cmd.page_add || cmd.init_wr || cmd.copy_wr;
    rank_addr  = src_r;
    rank_wdata = next_rdata;
    if (cmd.page_add) begin
      rank_addr  = pt_r[PAGE_W-1:0];
      rank_wdata = '0;
    end else if (cmd.read_begin) begin
      rank_addr = idx_r;
    end else if (cmd.init_wr || cmd.copy_wr) begin
      rank_addr = sweep_idx;
      if (cmd.init_wr) rank_wdata = start_r;
    end
  end

  // Next-weight table port with saturating accumulate.
  always_comb begin
    acc_sum    = {1'b0, next_rdata} + {1'b0, div_quo[Q_W-1:0]};
    next_we    = cmd.next_init_wr || cmd.acc_wr;
    next_addr  = (cmd.next_init_wr || cmd.copy_rd) ? sweep_idx : dst_r;
    next_wdata = cmd.next_init_wr ? base_r :
                 (acc_sum[Q_W] ? '1 : acc_sum[Q_W-1:0]);
  end

  // Edge table port.
  always_comb begin
    edge_we    = cmd.link_begin;
    edge_addr  = cmd.link_begin ? et_r[EDGE_W-1:0] : cnt_r[EDGE_W-1:0];
    edge_wdata = {last_page, idx_r};
  end

  prpi_ram #(.WIDTH(DEG_W), .DEPTH(MAX_PAGES)) u_deg_ram (
    .clk (clk), .we (deg_we), .addr (deg_addr), .wdata (deg_wdata), .rdata (deg_rdata)
  );
  prpi_ram #(.WIDTH(Q_W), .DEPTH(MAX_PAGES)) u_rank_ram (
    .clk (clk), .we (rank_we), .addr (rank_addr), .wdata (rank_wdata), .rdata (rank_rdata)
  );
  prpi_ram #(.WIDTH(Q_W), .DEPTH(MAX_PAGES)) u_next_ram (
    .clk (clk), .we (next_we), .addr (next_addr), .wdata (next_wdata), .rdata (next_rdata)
  );
  prpi_ram #(.WIDTH(EDGE_DATA_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk (clk), .we (edge_we), .addr (edge_addr), .wdata (edge_wdata), .rdata (edge_rdata)
  );

  // Control counters and the iteration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r   <= '0;
      et_r   <= '0;
      cnt_r  <= '0;
      pass_r <= '0;
      iter_r <= ITER_RESET;
    end else begin
      if (cfg_we) iter_r <= cfg_wdata;
      if (cmd.page_add) pt_r <= pt_r + PAGE_CNT_W'(1);
      if (cmd.link_begin) et_r <= et_r + EDGE_CNT_W'(1);
      if (cmd.cnt_clr) cnt_r <= '0;
      else if (cmd.cnt_inc) cnt_r <= cnt_r + EDGE_CNT_W'(1);
      if (cmd.pass_clr) pass_r <= '0;
      else if (cmd.pass_inc) pass_r <= pass_r + ITER_W'(1);
    end
  end

  // Request fields, edge endpoints and pass constants.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r        <= req_t'(in_req_type);
      idx_r        <= in_page_index;
      res_value_r  <= '0;
      res_status_r <= 1'b0;
    end else begin
      if (cmd.reject) res_status_r <= 1'b1;
      if (cmd.read_end) res_value_r <= rank_rdata;
    end
    if (cmd.edge_take) begin
      src_r <= edge_rdata[EDGE_DATA_W-1:PAGE_W];
      dst_r <= edge_rdata[PAGE_W-1:0];
    end
    if (cmd.take_start) start_r <= (div_quo[DIVD_W-1:Q_W] != '0) ? '1 : div_quo[Q_W-1:0];
    if (cmd.take_base) base_r <= div_quo[Q_W-1:0];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rank_value = out_value_r;
  assign out_status     = out_status_r;
  assign iter_count     = iter_r;

  a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pt_r <= PAGE_CNT_W'(MAX_PAGES))
    else $error("page count beyond table size");

  a_edges_bound: assert property (@(posedge clk) disable iff (!rst_n)
    et_r <= EDGE_CNT_W'(MAX_EDGES))
    else $error("edge count beyond table size");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> div_busy)
    else $error("divider did not start");

endmodule

// ===== rtl/pagerank_power_iteration.sv =====
`timescale 1ns / 1ps
// Channel   Port     Dir  Transfer contents
// request   in_ch    in   req_type[1:0], page_index[9:0]
// result    out_ch   out  rank_value[31:0], status
// config    cfg_*    in   APB write of iteration_count at byte addresses 0 to 3
//
// One request is worked at a time. A compute request is paced by the
// one-bit-per-cycle divider and the single-port tables. Reset is synchronous
// and needs no clearing pass. A result waits in the output register; the next
// request is taken meanwhile.
module pagerank_power_iteration
  import prpi_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  prpi_req_if.sink          in_ch,
  prpi_res_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  prpi_cmd_t         cmd;
  prpi_stat_t        stat;
  logic              cfg_we;
  logic [ITER_W-1:0] iter_count;

  // Register write on the access phase.
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? '0 : {{(32-ITER_W){1'b0}}, iter_count};

  prpi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  prpi_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (in_ch.req_type),
    .in_page_index  (in_ch.page_index),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_pwdata[ITER_W-1:0]),
    .iter_count     (iter_count),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_rank_value (out_ch.rank_value),
    .out_status     (out_ch.status)
  );

endmodule
